>>> sv/sfsc_pkg.sv
// ----------------------------------------------------------------------------
// sfsc_pkg
// Shared types and constants of the serial frame and string capture unit.
// ----------------------------------------------------------------------------
package sfsc_pkg;

	localparam int unsigned MAX_LINE_BYTES = 4096;
	localparam int unsigned LINE_W         = $clog2(MAX_LINE_BYTES) + 1;
	localparam int unsigned OFF_W          = $clog2(MAX_LINE_BYTES);
	localparam int unsigned STR_IDX_W      = 4;
	localparam int unsigned CFG_DATA_W     = LINE_W;

	localparam logic [LINE_W-1:0] MAX_LINE_LEN = LINE_W'(MAX_LINE_BYTES);

	localparam logic [LINE_W-1:0]    RST_LINE_BYTES      = LINE_W'(3840);
	localparam logic [7:0]           RST_LINES_PER_FRAME = 8'd30;
	localparam logic [STR_IDX_W-1:0] RST_NAME_LIMIT      = 4'd9;
	localparam logic [STR_IDX_W-1:0] RST_ADDR_LIMIT      = 4'd15;
	localparam logic [7:0]           RST_START_MARKER    = 8'h5A;
	localparam logic [7:0]           RST_END_MARKER      = 8'hA5;
	localparam logic [7:0]           RST_NAME_TAG        = 8'h4E;
	localparam logic [7:0]           RST_ADDR_TAG        = 8'h49;

	typedef enum logic [2:0] {
		REG_LINE_BYTES      = 3'd0,
		REG_LINES_PER_FRAME = 3'd1,
		REG_NAME_LIMIT      = 3'd2,
		REG_ADDR_LIMIT      = 3'd3,
		REG_START_MARKER    = 3'd4,
		REG_END_MARKER      = 3'd5,
		REG_NAME_TAG        = 3'd6,
		REG_ADDR_TAG        = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		STR_IDLE = 2'd0,
		STR_NAME = 2'd1,
		STR_ADDR = 2'd2
	} str_mode_t;

	typedef struct packed {
		logic [LINE_W-1:0]    line_bytes;
		logic [7:0]           lines_per_frame;
		logic [STR_IDX_W-1:0] name_limit;
		logic [STR_IDX_W-1:0] addr_limit;
		logic [7:0]           start_marker;
		logic [7:0]           end_marker;
		logic [7:0]           name_tag;
		logic [7:0]           addr_tag;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       hold_off;
	} in_item_t;

	typedef struct packed {
		logic                 img_write;
		logic                 img_bank;
		logic [OFF_W-1:0]     img_offset;
		logic [7:0]           img_byte;
		logic                 line_done;
		logic                 frame_done;
		logic                 image_start;
		logic                 str_write;
		logic                 str_select;
		logic [STR_IDX_W-1:0] str_index;
		logic [7:0]           str_char;
		logic                 str_done;
	} out_item_t;

endpackage

>>> sv/sfsc_cfg.sv
// ----------------------------------------------------------------------------
// sfsc_cfg
// Configuration register file; decodes index and captures masked data.
// ----------------------------------------------------------------------------
module sfsc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  sfsc_pkg::reg_index_t           wr_index,
	input  logic [sfsc_pkg::CFG_DATA_W-1:0] wr_data,
	output sfsc_pkg::cfg_t                 cfg
);
	import sfsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_bytes      <= RST_LINE_BYTES;
			cfg_q.lines_per_frame <= RST_LINES_PER_FRAME;
			cfg_q.name_limit      <= RST_NAME_LIMIT;
			cfg_q.addr_limit      <= RST_ADDR_LIMIT;
			cfg_q.start_marker    <= RST_START_MARKER;
			cfg_q.end_marker      <= RST_END_MARKER;
			cfg_q.name_tag        <= RST_NAME_TAG;
			cfg_q.addr_tag        <= RST_ADDR_TAG;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LINE_BYTES:      cfg_q.line_bytes      <= wr_data[LINE_W-1:0];
				REG_LINES_PER_FRAME: cfg_q.lines_per_frame <= wr_data[7:0];
				REG_NAME_LIMIT:      cfg_q.name_limit      <= wr_data[STR_IDX_W-1:0];
				REG_ADDR_LIMIT:      cfg_q.addr_limit      <= wr_data[STR_IDX_W-1:0];
				REG_START_MARKER:    cfg_q.start_marker    <= wr_data[7:0];
				REG_END_MARKER:      cfg_q.end_marker      <= wr_data[7:0];
				REG_NAME_TAG:        cfg_q.name_tag        <= wr_data[7:0];
				REG_ADDR_TAG:        cfg_q.addr_tag        <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/sfsc_step.sv
// ----------------------------------------------------------------------------
// sfsc_step
// Capture state and steering logic for one byte: line store, strings, starts.
// ----------------------------------------------------------------------------
module sfsc_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  sfsc_pkg::cfg_t      cfg,
	input  sfsc_pkg::in_item_t  item,
	output sfsc_pkg::out_item_t result
);
	import sfsc_pkg::*;

	logic                 capture_q;
	logic                 bank_q;
	logic [OFF_W-1:0]     offset_q;
	logic [7:0]           line_cnt_q;
	str_mode_t            mode_q;
	logic [STR_IDX_W-1:0] str_idx_q;

	logic [LINE_W-1:0]    len_eff;
	logic [7:0]           lpf_eff;
	logic [LINE_W-1:0]    off_inc;
	logic [8:0]           cnt_inc;
	logic                 line_end;
	logic                 frame_end;
	logic                 capture_mid;
	logic                 str_act;
	logic [STR_IDX_W-1:0] str_lim;
	logic                 str_term;
	str_mode_t            mode_mid;
	logic                 start_img;
	logic                 capture_next;
	str_mode_t            mode_next;

	always_comb begin
		if (cfg.line_bytes > MAX_LINE_LEN)
			len_eff = MAX_LINE_LEN;
		else if (cfg.line_bytes == '0)
			len_eff = LINE_W'(1);
		else
			len_eff = cfg.line_bytes;
		lpf_eff = (cfg.lines_per_frame == 8'd0) ? 8'd1 : cfg.lines_per_frame;

		off_inc   = {1'b0, offset_q} + LINE_W'(1);
		cnt_inc   = {1'b0, line_cnt_q} + 9'd1;
		line_end  = capture_q && (off_inc >= len_eff);
		frame_end = line_end && (cnt_inc >= {1'b0, lpf_eff});
		capture_mid = capture_q && !frame_end;

		str_act  = (mode_q == STR_NAME) || (mode_q == STR_ADDR);
		str_lim  = (mode_q == STR_NAME) ? cfg.name_limit : cfg.addr_limit;
		str_term = str_act && ((item.rx_byte == cfg.end_marker) || (str_idx_q >= str_lim));
		mode_mid = (str_act && !str_term) ? mode_q : STR_IDLE;

		start_img = (item.rx_byte == cfg.start_marker) && !capture_mid &&
		            !item.hold_off && (mode_mid == STR_IDLE);
		capture_next = capture_mid || start_img;

		mode_next = mode_mid;
		if (!capture_next && (mode_mid == STR_IDLE)) begin
			if (item.rx_byte == cfg.name_tag)
				mode_next = STR_NAME;
			else if (item.rx_byte == cfg.addr_tag)
				mode_next = STR_ADDR;
		end
	end

	always_comb begin
		result             = '0;
		result.img_write   = capture_q;
		result.line_done   = line_end;
		result.frame_done  = frame_end;
		result.image_start = start_img;
		if (capture_q) begin
			result.img_bank   = bank_q;
			result.img_offset = offset_q;
			result.img_byte   = item.rx_byte;
		end
		result.str_write = str_act;
		result.str_done  = str_term;
		if (str_act) begin
			result.str_select = (mode_q == STR_ADDR);
			result.str_index  = str_idx_q;
			result.str_char   = str_term ? 8'd0 : item.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q  <= 1'b0;
			bank_q     <= 1'b0;
			offset_q   <= '0;
			line_cnt_q <= '0;
			mode_q     <= STR_IDLE;
			str_idx_q  <= '0;
		end else if (advance) begin
			capture_q <= capture_next;
			mode_q    <= mode_next;
			if (capture_q)
				offset_q <= line_end ? '0 : off_inc[OFF_W-1:0];
			if (line_end) begin
				bank_q     <= ~bank_q;
				line_cnt_q <= frame_end ? 8'd0 : cnt_inc[7:0];
			end
			if (str_act)
				str_idx_q <= str_term ? '0 : str_idx_q + STR_IDX_W'(1);
		end
	end

endmodule

>>> sv/serial_frame_and_string_capture_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_and_string_capture_unit
// Steers received serial bytes into a ping-pong line store and two strings.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle with no bubbles while the output does
// not stall: a byte is registered on transfer, resolved against the capture
// state while it sits in the input register, and its result lands in the
// output register when the step advances; the rate is set by the single
// capture/steering stage. Input stall follows output stall only when both
// the input and output registers are full. Configuration writes are always
// ready and must be made while no byte is in flight.
module serial_frame_and_string_capture_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  sfsc_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output sfsc_pkg::out_item_t             out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  sfsc_pkg::reg_index_t            cfg_index,
	input  logic [sfsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfsc_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t item_s2;
	logic      valid_s2;
	logic      advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	sfsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sfsc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= in_item;
		if (advance)
			item_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

>>> verif/tb_serial_frame_and_string_capture_unit.sv
// ----------------------------------------------------------------------------
// tb_serial_frame_and_string_capture_unit
// Self-checking bench for the serial frame and string capture unit.
// A scoreboard class tracks the capture state and the register file. It
// turns every byte accepted at the input into the expected line store and
// string write. Results are matched in order, field by field. The stimulus
// starts with hand-picked bytes at reset and at edge settings. It then sends
// framed images, tagged strings and noise under fixed edge and random
// register settings, with random gaps on both sides and a long receiver
// hold-off. A capture at the saturated line length closes the run.
// ----------------------------------------------------------------------------
module tb_serial_frame_and_string_capture_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sfsc_pkg::*;

	class capture_scoreboard;
		cfg_t        regs;
		bit          capturing;
		bit          bank;
		int unsigned offset;
		int unsigned line_cnt;
		str_mode_t   mode;
		int unsigned str_pos;
		out_item_t   expected_q[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned frames_seen;
		int unsigned strings_seen;

		function new();
			regs = '{RST_LINE_BYTES, RST_LINES_PER_FRAME, RST_NAME_LIMIT, RST_ADDR_LIMIT,
				RST_START_MARKER, RST_END_MARKER, RST_NAME_TAG, RST_ADDR_TAG};
			capturing = 1'b0;
			bank      = 1'b0;
			offset    = 0;
			line_cnt  = 0;
			mode      = STR_IDLE;
			str_pos   = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_LINE_BYTES:      regs.line_bytes      = v;
				REG_LINES_PER_FRAME: regs.lines_per_frame = v[7:0];
				REG_NAME_LIMIT:      regs.name_limit      = v[STR_IDX_W-1:0];
				REG_ADDR_LIMIT:      regs.addr_limit      = v[STR_IDX_W-1:0];
				REG_START_MARKER:    regs.start_marker    = v[7:0];
				REG_END_MARKER:      regs.end_marker      = v[7:0];
				REG_NAME_TAG:        regs.name_tag        = v[7:0];
				REG_ADDR_TAG:        regs.addr_tag        = v[7:0];
				default: ;
			endcase
		endfunction

		function void note_byte(in_item_t it);
			out_item_t   e;
			int unsigned len;
			int unsigned frame_lines;
			int unsigned lim;
			e = '0;
			if (capturing) begin
				len = (regs.line_bytes > MAX_LINE_LEN) ? MAX_LINE_BYTES : regs.line_bytes;
				if (len == 0)
					len = 1;
				frame_lines = (regs.lines_per_frame == 0) ? 1 : regs.lines_per_frame;
				e.img_write  = 1'b1;
				e.img_bank   = bank;
				e.img_offset = OFF_W'(offset);
				e.img_byte   = it.rx_byte;
				offset++;
				if (offset >= len) begin
					offset      = 0;
					bank        = ~bank;
					e.line_done = 1'b1;
					line_cnt++;
					if (line_cnt >= frame_lines) begin
						line_cnt     = 0;
						capturing    = 1'b0;
						e.frame_done = 1'b1;
					end
				end
			end
			if (mode != STR_IDLE) begin
				lim = (mode == STR_NAME) ? regs.name_limit : regs.addr_limit;
				e.str_write  = 1'b1;
				e.str_select = (mode == STR_ADDR);
				e.str_index  = STR_IDX_W'(str_pos);
				if (it.rx_byte == regs.end_marker || str_pos >= lim) begin
					e.str_done = 1'b1;
					mode       = STR_IDLE;
					str_pos    = 0;
				end else begin
					e.str_char = it.rx_byte;
					str_pos++;
				end
			end
			if (!capturing && mode == STR_IDLE) begin
				if (it.rx_byte == regs.start_marker && !it.hold_off) begin
					capturing     = 1'b1;
					e.image_start = 1'b1;
				end else if (it.rx_byte == regs.name_tag) begin
					mode = STR_NAME;
				end else if (it.rx_byte == regs.addr_tag) begin
					mode = STR_ADDR;
				end
			end
			expected_q.push_back(e);
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task cmp(string field, logic [15:0] got_v, logic [15:0] exp_v);
			if (got_v !== exp_v)
				report($sformatf("result %0d %s: got %0h, expected %0h",
					checked, field, got_v, exp_v));
		endtask

		task check_result(out_item_t got);
			out_item_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result with no byte outstanding: %h", got));
			end else begin
				e = expected_q.pop_front();
				cmp("img_write", got.img_write, e.img_write);
				cmp("img_bank", got.img_bank, e.img_bank);
				cmp("img_offset", got.img_offset, e.img_offset);
				cmp("img_byte", got.img_byte, e.img_byte);
				cmp("line_done", got.line_done, e.line_done);
				cmp("frame_done", got.frame_done, e.frame_done);
				cmp("image_start", got.image_start, e.image_start);
				cmp("str_write", got.str_write, e.str_write);
				cmp("str_select", got.str_select, e.str_select);
				cmp("str_index", got.str_index, e.str_index);
				cmp("str_char", got.str_char, e.str_char);
				cmp("str_done", got.str_done, e.str_done);
				if (e.frame_done)
					frames_seen++;
				if (e.str_done)
					strings_seen++;
				checked++;
			end
		endtask

		task check_drained();
			if (expected_q.size() != 0)
				report($sformatf("%0d results never arrived", expected_q.size()));
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_index_t            cfg_index = REG_LINE_BYTES;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	capture_scoreboard sb;
	cfg_t              cur_cfg;
	int unsigned       send_gap_pct   = 0;
	int unsigned       recv_stall_pct = 0;
	int unsigned       hold_reqs      = 0;
	int unsigned       holds_served   = 0;
	int unsigned       settings_count = 0;

	localparam int unsigned LONG_HOLD = 200;

	serial_frame_and_string_capture_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_served) begin
				holds_served++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_item);
	end

	task automatic send_byte(input logic [7:0] b, input logic h);
		while ($urandom_range(99, 0) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{rx_byte: b, hold_off: h};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte('{rx_byte: b, hold_off: h});
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// hold valid across back-to-back writes; caller drops it
	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic apply_config(input cfg_t c);
		write_reg(REG_LINE_BYTES, c.line_bytes);
		write_reg(REG_LINES_PER_FRAME, {5'($urandom), c.lines_per_frame});
		write_reg(REG_NAME_LIMIT, {9'($urandom), c.name_limit});
		write_reg(REG_ADDR_LIMIT, {9'($urandom), c.addr_limit});
		write_reg(REG_START_MARKER, {5'($urandom), c.start_marker});
		write_reg(REG_END_MARKER, {5'($urandom), c.end_marker});
		write_reg(REG_NAME_TAG, {5'($urandom), c.name_tag});
		write_reg(REG_ADDR_TAG, {5'($urandom), c.addr_tag});
		cfg_valid <= 1'b0;
		@(posedge clk);
		cur_cfg = c;
		settings_count++;
	endtask

	function automatic cfg_t random_settings();
		cfg_t c;
		c.line_bytes      = ($urandom_range(9, 0) == 0) ? LINE_W'($urandom)
			: LINE_W'($urandom_range(6, 1));
		c.lines_per_frame = 8'($urandom_range(4, 0));
		c.name_limit      = STR_IDX_W'($urandom);
		c.addr_limit      = STR_IDX_W'($urandom);
		c.start_marker    = 8'($urandom);
		c.end_marker      = 8'($urandom);
		c.name_tag        = 8'($urandom);
		c.addr_tag        = 8'($urandom);
		return c;
	endfunction

	// mostly whole frames and terminated strings, some noise in between
	task automatic run_traffic(input int unsigned n);
		int unsigned sent;
		int unsigned pick;
		int unsigned len;
		int unsigned line_len;
		int unsigned frame_lines;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99, 0);
			if (pick < 45) begin
				line_len    = (cur_cfg.line_bytes == 0) ? 1 : cur_cfg.line_bytes;
				frame_lines = (cur_cfg.lines_per_frame == 0) ? 1 : cur_cfg.lines_per_frame;
				len         = line_len * frame_lines;
				if (len > 48)
					len = $urandom_range(48, 1);
				send_byte(cur_cfg.start_marker, $urandom_range(9, 0) == 0);
				repeat (len) send_byte(8'($urandom), 1'($urandom));
				sent += len + 1;
			end else if (pick < 80) begin
				len = $urandom_range(17, 0);
				send_byte((pick < 62) ? cur_cfg.name_tag : cur_cfg.addr_tag, 1'($urandom));
				repeat (len) send_byte(8'($urandom), 1'($urandom));
				send_byte(cur_cfg.end_marker, 1'($urandom));
				sent += len + 2;
			end else begin
				send_byte(8'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		cfg_t c;
		sb = new();
		cur_cfg = sb.regs;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct   = 37;
		recv_stall_pct = 74;
		send_byte(RST_START_MARKER, 1'b1);
		send_byte(RST_NAME_TAG, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(RST_START_MARKER, 1'b0);
		send_byte(RST_END_MARKER, 1'b0);
		send_byte(RST_ADDR_TAG, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(RST_END_MARKER, 1'b0);
		send_byte(RST_START_MARKER, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(RST_NAME_TAG, 1'b0);
		send_byte(RST_END_MARKER, 1'b0);
		wait_drained();

		// zero line, frame and name sizes, start marker equal to both tags
		apply_config('{'0, 8'd0, 4'd0, 4'd15, 8'h33, 8'h00, 8'h33, 8'h33});
		send_byte(8'h33, 1'b0);
		send_byte(8'h33, 1'b1);
		send_byte(8'h44, 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'h00, 1'b0);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_gap_pct   = 74;
				recv_stall_pct = 37;
			end else if (ph == 4) begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			if (ph == 0)
				c = '{'0, 8'd0, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00};
			else if (ph == 1)
				c = '{'1, 8'hFF, 4'hF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
			else
				c = random_settings();
			apply_config(c);
			if (ph == 4)
				hold_reqs <= hold_reqs + 1;
			run_traffic(100);
			wait_drained();
		end

		// close any open capture, then part of a line at the saturated length
		apply_config('{LINE_W'(1), 8'd1, 4'd0, 4'd0, RST_START_MARKER, RST_END_MARKER,
			RST_NAME_TAG, RST_ADDR_TAG});
		send_byte(8'h11, 1'b0);
		wait_drained();
		write_reg(REG_LINE_BYTES, '1);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_byte(RST_START_MARKER, 1'b0);
		repeat (64) send_byte(8'($urandom), 1'($urandom));
		wait_drained();

		sb.check_drained();
		$display("Covered %0d bytes under %0d register settings: %0d frames, %0d strings closed",
			sb.checked, settings_count, sb.frames_seen, sb.strings_seen);
		$display("Idling on both sides in three mixes, %0d long receiver hold-off(s)",
			holds_served);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d results outstanding", sb.expected_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
